[hw/rtl/adx_pkg.sv]
`default_nettype none
package adx_pkg;
   localparam int PRICE_BITS  = 32;
   localparam int SUM_BITS    = 48;
   localparam int OUT_BITS    = 23;
   localparam int SEED_BITS   = 31;
   localparam int IDX_BITS    = 9;
   localparam int PERIOD_BITS = 8;
   localparam int DVD_BITS    = 71;
   localparam int CNT_BITS    = 7;

   localparam logic [OUT_BITS-1:0] HUNDRED_Q = 23'd6553600;
   localparam logic [SUM_BITS-1:0] SUM_MAX   = {SUM_BITS{1'b1}};

   // divider command: start pulse and number of dividend bits to walk
   typedef struct packed {
      logic                start;
      logic [CNT_BITS-1:0] nbits;
   } div_cmd_type;
endpackage
`default_nettype wire

[hw/rtl/wilder_adx_directional_index.sv]
// Wilder average directional index, one price bar per beat.
// req_ channel: one bar per beat, tdata = {close, low, high}, see port comments,
// tuser flags the first bar of a new series (all running state is cleared).
// rsp_ channel: one result beat per bar with DI+, DI-, ADX and their valid flags.
// csr_ channel: writes the smoothing period (0 acts as 1); take it while idle.
// Flow: a bar is accepted only when the engine is idle and
// runs through a sequencer around one shared bit-serial divider. Bar zero
// goes from the decode step straight to the output step. A later bar
// uses up to three 48-bit sum divisions (none while seeding), up to three
// 71-bit percentage divisions (skipped when the denominator is 0 or the
// ratio reaches 100), at most one ADX division (31-bit seed, 32-bit smoothing),
// plus the accept, decode and output steps; a new bar is taken after the output step.
// The divider walks one dividend bit per cycle, so the dividend widths set each division's run.
// The result sits in an output register, so a new bar can be computed while
// the previous result waits; the sequencer holds at its last step only if
// that register is still full when the next result is ready.
// Reset (synchronous, active high) clears all series state, sets the
// period to 14 and drops rsp_tvalid. A stalled receiver holds rsp_ stable.
`default_nettype none
module wilder_adx_directional_index (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // bar_high, bar_low, bar_close
   input  wire logic        req_tuser,   // series_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // di_plus, di_minus, adx_value, zero pad
   output logic [1:0]       rsp_tuser,   // di_valid, adx_valid
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data     // smoothing_period
);
   typedef enum logic [3:0] {
      S_IDLE, S_CALC, S_SUMGO, S_PCTGO, S_PCTMUL, S_ADXGO, S_DSTART, S_DWAIT, S_FIN
   } state_type;

   typedef enum logic [1:0] {PH_SUM, PH_PCT, PH_ADX} phase_type;

   state_type state_ff;
   phase_type phase_ff;

   logic [adx_pkg::PERIOD_BITS-1:0] period_ff;
   logic [adx_pkg::PRICE_BITS-1:0]  hi_ff, lo_ff, cl_ff, ph_ff, pl_ff, pc_ff;
   logic [adx_pkg::PRICE_BITS-1:0]  tr_ff, pm_ff, mm_ff;
   logic [adx_pkg::IDX_BITS-1:0]    idx_ff;
   logic [adx_pkg::SUM_BITS-1:0]    trs_ff, pms_ff, mms_ff;
   logic [adx_pkg::SEED_BITS-1:0]   seed_ff;
   logic [adx_pkg::OUT_BITS-1:0]    adx_ff, dip_ff, dim_ff, dx_ff;
   logic                            adx_ok_ff;
   logic [1:0]                      k_ff;
   logic [adx_pkg::SUM_BITS-1:0]    num_ff;

   logic [adx_pkg::DVD_BITS-1:0]    dvd_ff;
   logic [adx_pkg::SUM_BITS-1:0]    dsr_ff;
   logic [adx_pkg::CNT_BITS-1:0]    nb_ff;
   adx_pkg::div_cmd_type            cmd;
   logic                            div_done;
   logic [adx_pkg::DVD_BITS-1:0]    div_q;

   logic                            rsp_v_ff;
   logic [71:0]                     rsp_d_ff;
   logic [1:0]                      rsp_u_ff;

   // period and index bounds
   logic [adx_pkg::PERIOD_BITS-1:0] p;
   logic [adx_pkg::IDX_BITS-1:0]    p_x, p2, p2m1;
   logic                            seeding, di_ok;
   logic [adx_pkg::IDX_BITS:0]      idx_inc;

   always_comb begin
      p       = (period_ff == '0) ? 8'd1 : period_ff;
      p_x     = {1'b0, p};
      p2      = {p, 1'b0};
      p2m1    = p2 - 9'd1;
      seeding = (idx_ff <= p_x);
      di_ok   = (idx_ff >= p_x) && (idx_ff != '0);
      idx_inc = {1'b0, idx_ff} + 10'd1;
   end

   // true range and directional movement
   logic signed [32:0] up_s, dn_s, r1_s, r2_s, r3_s, tr_s;
   always_comb begin
      up_s = $signed({1'b0, hi_ff}) - $signed({1'b0, ph_ff});
      dn_s = $signed({1'b0, pl_ff}) - $signed({1'b0, lo_ff});
      r1_s = $signed({1'b0, hi_ff}) - $signed({1'b0, lo_ff});
      r2_s = $signed({1'b0, hi_ff}) - $signed({1'b0, pc_ff});
      r3_s = $signed({1'b0, lo_ff}) - $signed({1'b0, pc_ff});
      if (r2_s < 0) r2_s = -r2_s;
      if (r3_s < 0) r3_s = -r3_s;
      tr_s = r1_s;
      if (r2_s > tr_s) tr_s = r2_s;
      if (r3_s > tr_s) tr_s = r3_s;
   end

   // selected wilder sum and its new term
   logic [adx_pkg::SUM_BITS-1:0] sum_sel;
   logic [adx_pkg::PRICE_BITS-1:0] x_sel;
   logic [adx_pkg::SUM_BITS-1:0] q_sub;
   logic [adx_pkg::SUM_BITS:0]   sum_raw;
   logic [adx_pkg::SUM_BITS-1:0] sum_in;
   always_comb begin
      case (k_ff)
         2'd0:    begin sum_sel = trs_ff; x_sel = tr_ff; end
         2'd1:    begin sum_sel = pms_ff; x_sel = pm_ff; end
         default: begin sum_sel = mms_ff; x_sel = mm_ff; end
      endcase
      q_sub   = (state_ff == S_DWAIT) ? div_q[adx_pkg::SUM_BITS-1:0] : '0;
      sum_raw = {1'b0, sum_sel} - {1'b0, q_sub} + {17'd0, x_sel};
      sum_in  = sum_raw[adx_pkg::SUM_BITS] ? adx_pkg::SUM_MAX
                                           : sum_raw[adx_pkg::SUM_BITS-1:0];
   end

   // percentage operands
   logic [adx_pkg::OUT_BITS-1:0]   di_diff;
   logic [adx_pkg::OUT_BITS:0]     di_total;
   logic [adx_pkg::SUM_BITS-1:0]   pnum, pden;
   always_comb begin
      di_diff  = (dip_ff > dim_ff) ? dip_ff - dim_ff : dim_ff - dip_ff;
      di_total = {1'b0, dip_ff} + {1'b0, dim_ff};
      case (k_ff)
         2'd0:    begin pnum = pms_ff; pden = trs_ff; end
         2'd1:    begin pnum = mms_ff; pden = trs_ff; end
         default: begin pnum = {25'd0, di_diff}; pden = {24'd0, di_total}; end
      endcase
   end

   // adx update terms
   logic [adx_pkg::SEED_BITS-1:0] seed_in;
   logic [31:0]                   smooth_in;
   logic [31:0]                   adx_q;
   always_comb begin
      seed_in   = seed_ff + {8'd0, dx_ff};
      smooth_in = 32'(adx_ff * (p - 8'd1)) + {9'd0, dx_ff};
      adx_q     = div_q[31:0];
   end

   assign cmd.start = (state_ff == S_DSTART);
   assign cmd.nbits = nb_ff;

   adx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .dividend (dvd_ff),
      .divisor  (dsr_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   logic                        accept;
   logic                        out_free;
   logic [adx_pkg::OUT_BITS-1:0] pct_res;
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_v_ff || rsp_tready;
   assign pct_res  = div_q[adx_pkg::OUT_BITS-1:0];

   // period register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 8'd14;
      end else if (csr_valid) begin
         period_ff <= csr_data;
      end
   end

   // sequencer, series state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= PH_SUM;
         rsp_v_ff  <= 1'b0;
         ph_ff     <= '0;
         pl_ff     <= '0;
         pc_ff     <= '0;
         idx_ff    <= '0;
         trs_ff    <= '0;
         pms_ff    <= '0;
         mms_ff    <= '0;
         seed_ff   <= '0;
         adx_ff    <= '0;
         adx_ok_ff <= 1'b0;
         k_ff      <= '0;
      end else begin
         // the output step reloads the register itself when it drains
         if (rsp_v_ff && rsp_tready && state_ff != S_FIN) rsp_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  hi_ff     <= req_tdata[31:0];
                  lo_ff     <= req_tdata[63:32];
                  cl_ff     <= req_tdata[95:64];
                  dip_ff    <= '0;
                  dim_ff    <= '0;
                  adx_ok_ff <= 1'b0;
                  if (req_tuser) begin
                     ph_ff   <= '0;
                     pl_ff   <= '0;
                     pc_ff   <= '0;
                     idx_ff  <= '0;
                     trs_ff  <= '0;
                     pms_ff  <= '0;
                     mms_ff  <= '0;
                     seed_ff <= '0;
                     adx_ff  <= '0;
                  end
                  state_ff <= S_CALC;
               end
            end
            S_CALC: begin
               tr_ff <= tr_s[31:0];
               pm_ff <= (up_s > dn_s && up_s > 0) ? up_s[31:0] : '0;
               mm_ff <= (dn_s > up_s && dn_s > 0) ? dn_s[31:0] : '0;
               k_ff  <= '0;
               state_ff <= (idx_ff == '0) ? S_FIN : S_SUMGO;
            end
            S_SUMGO: begin
               if (seeding) begin
                  case (k_ff)
                     2'd0:    trs_ff <= sum_in;
                     2'd1:    pms_ff <= sum_in;
                     default: mms_ff <= sum_in;
                  endcase
                  if (k_ff == 2'd2) begin
                     k_ff     <= '0;
                     state_ff <= di_ok ? S_PCTGO : S_FIN;
                  end else begin
                     k_ff <= k_ff + 2'd1;
                  end
               end else begin
                  dvd_ff   <= {sum_sel, 23'd0};
                  dsr_ff   <= {40'd0, p};
                  nb_ff    <= 7'd48;
                  phase_ff <= PH_SUM;
                  state_ff <= S_DSTART;
               end
            end
            S_PCTGO: begin
               if (pden == '0 || pnum >= pden) begin
                  case (k_ff)
                     2'd0:    dip_ff <= (pden == '0) ? '0 : adx_pkg::HUNDRED_Q;
                     2'd1:    dim_ff <= (pden == '0) ? '0 : adx_pkg::HUNDRED_Q;
                     default: dx_ff  <= (pden == '0) ? '0 : adx_pkg::HUNDRED_Q;
                  endcase
                  if (k_ff == 2'd2) begin
                     state_ff <= S_ADXGO;
                  end else begin
                     k_ff <= k_ff + 2'd1;
                  end
               end else begin
                  num_ff   <= pnum;
                  dsr_ff   <= pden;
                  state_ff <= S_PCTMUL;
               end
            end
            S_PCTMUL: begin
               // 100 * num, then 16 fraction bits below it
               dvd_ff   <= {55'(num_ff * 7'd100), 16'd0};
               nb_ff    <= 7'd71;
               phase_ff <= PH_PCT;
               state_ff <= S_DSTART;
            end
            S_ADXGO: begin
               dsr_ff   <= {40'd0, p};
               phase_ff <= PH_ADX;
               if (idx_ff <= p2m1) begin
                  seed_ff <= seed_in;
                  if (idx_ff == p2m1) begin
                     dvd_ff   <= {seed_in, 40'd0};
                     nb_ff    <= 7'd31;
                     state_ff <= S_DSTART;
                  end else begin
                     state_ff <= S_FIN;
                  end
               end else begin
                  dvd_ff   <= {smooth_in, 39'd0};
                  nb_ff    <= 7'd32;
                  state_ff <= S_DSTART;
               end
            end
            S_DSTART: begin
               state_ff <= S_DWAIT;
            end
            S_DWAIT: begin
               if (div_done) begin
                  case (phase_ff)
                     PH_SUM: begin
                        case (k_ff)
                           2'd0:    trs_ff <= sum_in;
                           2'd1:    pms_ff <= sum_in;
                           default: mms_ff <= sum_in;
                        endcase
                        if (k_ff == 2'd2) begin
                           k_ff     <= '0;
                           state_ff <= di_ok ? S_PCTGO : S_FIN;
                        end else begin
                           k_ff     <= k_ff + 2'd1;
                           state_ff <= S_SUMGO;
                        end
                     end
                     PH_PCT: begin
                        case (k_ff)
                           2'd0:    dip_ff <= pct_res;
                           2'd1:    dim_ff <= pct_res;
                           default: dx_ff  <= pct_res;
                        endcase
                        if (k_ff == 2'd2) begin
                           state_ff <= S_ADXGO;
                        end else begin
                           k_ff     <= k_ff + 2'd1;
                           state_ff <= S_PCTGO;
                        end
                     end
                     default: begin
                        adx_ff    <= (adx_q > {9'd0, adx_pkg::HUNDRED_Q}) ?
                                     adx_pkg::HUNDRED_Q : adx_q[adx_pkg::OUT_BITS-1:0];
                        adx_ok_ff <= 1'b1;
                        state_ff  <= S_FIN;
                     end
                  endcase
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_v_ff <= 1'b1;
                  rsp_d_ff <= {3'd0, (adx_ok_ff ? adx_ff : 23'd0), dim_ff, dip_ff};
                  rsp_u_ff <= {adx_ok_ff, di_ok};
                  ph_ff    <= hi_ff;
                  pl_ff    <= lo_ff;
                  pc_ff    <= cl_ff;
                  idx_ff   <= (idx_inc < {1'b0, p2}) ? idx_inc[adx_pkg::IDX_BITS-1:0] : p2;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;
   assign rsp_tuser  = rsp_u_ff;
endmodule
`default_nettype wire

[hw/rtl/adx_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle, dividend left aligned
module adx_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire adx_pkg::div_cmd_type              cmd,
   input  wire logic [adx_pkg::DVD_BITS-1:0]      dividend,
   input  wire logic [adx_pkg::SUM_BITS-1:0]      divisor,
   output logic                                   done,
   output logic [adx_pkg::DVD_BITS-1:0]           quotient
);
   logic [adx_pkg::DVD_BITS-1:0] work_ff;
   logic [adx_pkg::SUM_BITS-1:0] rem_ff;
   logic [adx_pkg::CNT_BITS-1:0] cnt_ff;
   logic                         busy_ff;
   logic                         done_ff;
   logic [adx_pkg::SUM_BITS:0]   trial;
   logic [adx_pkg::SUM_BITS:0]   diff;
   logic                         qbit;

   always_comb begin
      trial = {rem_ff, work_ff[adx_pkg::DVD_BITS-1]};
      diff  = trial - {1'b0, divisor};
      qbit  = (trial >= {1'b0, divisor});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // pulse after the last quotient bit
         done_ff <= !cmd.start && busy_ff && (cnt_ff == 7'd1);
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.nbits;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         work_ff <= dividend;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         work_ff <= {work_ff[adx_pkg::DVD_BITS-2:0], qbit};
         rem_ff  <= qbit ? diff[adx_pkg::SUM_BITS-1:0] : trial[adx_pkg::SUM_BITS-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff;
endmodule
`default_nettype wire

[hw/rtl/adx_chk.sv]
`default_nettype none
module adx_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);
   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // adx can only be valid once the indicators are
   a_adx_after_di: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tuser[1] || rsp_tuser[0])
      else $error("adx valid without di valid");

   a_di_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[45:0] == 46'd0)
      else $error("indicators nonzero while not valid");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:0] <= 23'd6553600 && rsp_tdata[45:23] <= 23'd6553600
                     && rsp_tdata[68:46] <= 23'd6553600)
      else $error("indicator above one hundred");
endmodule

bind wilder_adx_directional_index adx_chk u_adx_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

[test/adx_checker.sv]
`timescale 1ns / 1ps
module adx_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [95:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [71:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [7:0]  csr_data,
   output int               fail_count,
   output int               pending
);
   typedef struct {
      logic [adx_pkg::OUT_BITS-1:0] di_plus;
      logic [adx_pkg::OUT_BITS-1:0] di_minus;
      logic                         di_valid;
      logic [adx_pkg::OUT_BITS-1:0] adx_value;
      logic                         adx_valid;
   } adx_result_type;

   adx_result_type result_q[$];

   logic [7:0]      period_reg;
   longint unsigned last_high, last_low, last_close;
   longint unsigned next_index;
   longint unsigned tr_total, plus_total, minus_total;
   longint unsigned dx_total, adx_held;

   localparam longint unsigned HUNDRED = 64'd6553600;
   localparam longint unsigned SUM_TOP = (64'd1 << 48) - 1;

   function automatic longint unsigned percent_of(longint unsigned num, longint unsigned den);
      logic [127:0] prod;
      if (den == 0) return 0;
      if (num >= den) return HUNDRED;
      prod = 128'(num) * 128'(HUNDRED);
      return 64'(prod / 128'(den));
   endfunction

   function automatic longint unsigned sum_sat(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > SUM_TOP) ? SUM_TOP : s;
   endfunction

   function automatic longint unsigned smooth(longint unsigned s, longint unsigned p,
                                              longint unsigned x, bit seeding);
      if (seeding) return sum_sat(s, x);
      return sum_sat(s - s / p, x);
   endfunction

   task automatic clear_state();
      last_high = 0; last_low = 0; last_close = 0;
      next_index = 0;
      tr_total = 0; plus_total = 0; minus_total = 0;
      dx_total = 0; adx_held = 0;
   endtask

   task automatic predict_bar(logic start, logic [31:0] h, logic [31:0] l, logic [31:0] c);
      longint unsigned p, i, pm, mm, tr, dip, dim, diff, dx;
      longint up, dn, r1, r2, r3;
      adx_result_type r;
      bit adx_ok;
      p = (period_reg == 0) ? 1 : period_reg;
      if (start) clear_state();
      i = next_index;
      dip = 0; dim = 0; adx_ok = 0;
      r = '{default: '0};
      if (i > 0) begin
         up = longint'(h) - longint'(last_high);
         dn = longint'(last_low) - longint'(l);
         r1 = longint'(h) - longint'(l);
         r2 = longint'(h) - longint'(last_close);
         r3 = longint'(l) - longint'(last_close);
         if (r2 < 0) r2 = -r2;
         if (r3 < 0) r3 = -r3;
         pm = (up > dn && up > 0) ? longint'(up) : 0;
         mm = (dn > up && dn > 0) ? longint'(dn) : 0;
         tr = r1;
         if (r2 > longint'(tr)) tr = r2;
         if (r3 > longint'(tr)) tr = r3;
         tr_total    = smooth(tr_total, p, tr, i <= p);
         plus_total  = smooth(plus_total, p, pm, i <= p);
         minus_total = smooth(minus_total, p, mm, i <= p);
         if (i >= p) begin
            r.di_valid = 1;
            dip = percent_of(plus_total, tr_total);
            dim = percent_of(minus_total, tr_total);
            diff = (dip > dim) ? dip - dim : dim - dip;
            dx = percent_of(diff, dip + dim);
            if (i <= 2 * p - 1) begin
               dx_total = (dx_total + dx) & 64'h7FFF_FFFF;
               if (i == 2 * p - 1) begin
                  adx_held = dx_total / p;
                  adx_ok = 1;
               end
            end else begin
               adx_held = (adx_held * (p - 1) + dx) / p;
               adx_ok = 1;
            end
            if (adx_held > HUNDRED) adx_held = HUNDRED;
            if (adx_ok) r.adx_value = adx_held[adx_pkg::OUT_BITS-1:0];
         end
      end
      last_high = h; last_low = l; last_close = c;
      next_index = (i + 1 < 2 * p) ? i + 1 : 2 * p;
      r.di_plus = dip[adx_pkg::OUT_BITS-1:0];
      r.di_minus = dim[adx_pkg::OUT_BITS-1:0];
      r.adx_valid = adx_ok;
      result_q.insert(result_q.size(), r);
   endtask

   always @(posedge clock) begin
      adx_result_type want, got;
      if (reset) begin
         period_reg = 8'd14;
         clear_state();
         result_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) period_reg = csr_data;
         if (req_tvalid && req_tready)
            predict_bar(req_tuser, req_tdata[31:0], req_tdata[63:32], req_tdata[95:64]);
         if (rsp_tvalid && rsp_tready) begin
            got.di_plus   = rsp_tdata[22:0];
            got.di_minus  = rsp_tdata[45:23];
            got.adx_value = rsp_tdata[68:46];
            got.di_valid  = rsp_tuser[0];
            got.adx_valid = rsp_tuser[1];
            if (result_q.size() == 0) begin
               $display("%0t unexpected result beat: expected none actual %p", $time, got);
               fail_count++;
            end else begin
               want = result_q[0];
               result_q.delete(0);
               if (want.di_plus !== got.di_plus) begin
                  $display("%0t di_plus: expected %0d actual %0d", $time, want.di_plus,
                           got.di_plus);
                  fail_count++;
               end
               if (want.di_minus !== got.di_minus) begin
                  $display("%0t di_minus: expected %0d actual %0d", $time, want.di_minus,
                           got.di_minus);
                  fail_count++;
               end
               if (want.di_valid !== got.di_valid) begin
                  $display("%0t di_valid: expected %0d actual %0d", $time, want.di_valid,
                           got.di_valid);
                  fail_count++;
               end
               if (want.adx_value !== got.adx_value) begin
                  $display("%0t adx_value: expected %0d actual %0d", $time, want.adx_value,
                           got.adx_value);
                  fail_count++;
               end
               if (want.adx_valid !== got.adx_valid) begin
                  $display("%0t adx_valid: expected %0d actual %0d", $time, want.adx_valid,
                           got.adx_valid);
                  fail_count++;
               end
            end
         end
      end
      pending = result_q.size();
   end
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;    // bar_high, bar_low, bar_close
   logic        req_tuser;    // series_start
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // di_plus, di_minus, adx_value, zero pad
   logic [1:0]  rsp_tuser;    // di_valid, adx_valid
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;     // smoothing_period
   int          fail_count;
   int          pending;

   // receiver controls
   bit          quiet;       // final part: no idling anywhere
   bit          long_hold;   // ask the receiver for one long stall
   logic [31:0] walk_px;     // random-walk price level

   wilder_adx_directional_index u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   adx_checker u_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog: cycles with no beat on any channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 20000) begin
            $display("wilder_adx_directional_index verification failed");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, one long hold on request, none at the end
   initial begin
      int burst;
      rsp_tready = 0;
      burst = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready = 0;
            repeat (3000) @(negedge clock);
            long_hold = 0;
            rsp_tready = 1;
         end else if (quiet) begin
            rsp_tready = 1;
         end else if (burst > 0) begin
            rsp_tready = 0;
            burst--;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_tready = 0;
            burst = $urandom_range(0, 15);
         end else begin
            rsp_tready = 1;
         end
      end
   end

   // one bar beat; valid stays high until the handshake, then a random gap unless quiet
   task automatic send_bar(logic start, logic [31:0] h, logic [31:0] l, logic [31:0] c);
      req_tvalid = 1;
      req_tuser  = start;
      req_tdata  = {c, l, h};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   // mostly a plausible random walk, some raw noise covering every bit
   task automatic random_bar(logic start_ok);
      logic [31:0] h, l, c, up_sp, dn_sp;
      logic        st;
      st = start_ok && ($urandom_range(0, 59) == 0);
      if ($urandom_range(0, 9) == 0) begin
         h = $urandom(); l = $urandom(); c = $urandom();
      end else begin
         if ($urandom_range(0, 1)) walk_px = walk_px + $urandom_range(0, 32'h0004_0000);
         else walk_px = walk_px - $urandom_range(0, 32'h0004_0000);
         if (walk_px < 32'h0010_0000 || walk_px > 32'hF000_0000) walk_px = 32'h0100_0000;
         up_sp = $urandom_range(0, 32'h0002_0000);
         dn_sp = $urandom_range(0, 32'h0002_0000);
         h = walk_px + up_sp;
         l = walk_px - dn_sp;
         c = l + ($urandom() % (up_sp + dn_sp + 1));
      end
      send_bar(st, h, l, c);
   endtask

   task automatic write_period(logic [7:0] value);
      req_tvalid = 0;
      while (pending != 0) @(negedge clock);
      repeat (500) @(negedge clock);
      csr_valid = 1;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic run_phase(logic [7:0] period, int bars, logic fresh);
      write_period(period);
      for (int k = 0; k < bars; k++) random_bar(1'b1);
      if (fresh) ; // series continues across the period change unless a start comes
   endtask

   initial begin
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = '0;
      req_tuser  = 0;
      csr_valid  = 0;
      csr_data   = '0;
      quiet      = 0;
      long_hold  = 0;
      walk_px    = 32'h0100_0000;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed, reset period 14: bar zero, zero range, extremes, broken bars
      send_bar(1, 32'h0, 32'h0, 32'h0);
      send_bar(0, 32'h0, 32'h0, 32'h0);
      send_bar(0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
      send_bar(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_bar(0, 32'h0, 32'hFFFF_FFFF, 32'h0);
      send_bar(0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      for (int k = 0; k < 12; k++)
         send_bar(0, 32'h0200_0000 + k * 32'h1_0000, 32'h01F0_0000 + k * 32'h1_0000,
                  32'h01F8_0000);
      for (int k = 0; k < 10; k++) random_bar(1'b0);
      send_bar(1, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678);
      send_bar(0, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678);

      // period 1: adx valid from bar one; change mid-series first
      write_period(8'd1);
      for (int k = 0; k < 20; k++) random_bar(1'b1);
      // zero acts as one
      write_period(8'd0);
      send_bar(1, 32'h0300_0000, 32'h0200_0000, 32'h0280_0000);
      for (int k = 0; k < 20; k++) random_bar(1'b1);

      // period 2, with a long receiver hold while the sender keeps offering
      write_period(8'd2);
      send_bar(1, 32'h0300_0000, 32'h0200_0000, 32'h0280_0000);
      long_hold = 1;
      for (int k = 0; k < 40; k++) random_bar(1'b1);

      run_phase(8'd3, 40, 0);
      run_phase(8'd7, 40, 0);
      run_phase(8'd14, 30, 0);

      // largest period: one series past the first indicator bars
      write_period(8'd255);
      send_bar(1, 32'h0300_0000, 32'h0200_0000, 32'h0280_0000);
      for (int k = 0; k < 262; k++) send_bar(0, $urandom(), $urandom(), $urandom());

      // back to small period, then a final part with no idling
      run_phase(8'd4, 40, 0);
      write_period(8'd5);
      quiet = 1;
      send_bar(1, 32'h0300_0000, 32'h0200_0000, 32'h0280_0000);
      for (int k = 0; k < 30; k++) random_bar(1'b0);

      req_tvalid = 0;
      while (pending != 0) @(negedge clock);
      repeat (500) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("wilder_adx_directional_index verification clean");
      else
         $display("wilder_adx_directional_index verification failed");
      $finish;
   end
endmodule
